[hw/rtl/grf_pkg.sv]
// ----------------------------------------------------------------------------
// grf_pkg
// Shared constants, status codes and controller command type for the
// group release FIFO.
// ----------------------------------------------------------------------------
package grf_pkg;

    // port field widths
    localparam int OP_W     = 2;
    localparam int GID_W    = 8;
    localparam int MASK_W   = 16;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 4;

    // parameter defaults
    localparam int DEF_QUEUE_DEPTH   = 8;
    localparam int DEF_MEMBER_COUNT  = 16;
    localparam int DEF_GROUP_ID_BITS = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADMIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADMITTED   = 4'd0;
    localparam logic [STATUS_W-1:0] ST_MARKED     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_WAITING    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DUP_ID     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_DUP_MEMBER = 4'd6;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_FULL       = 4'd8;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // load the accepted item
        logic commit;   // apply the item and load the result register
    } t_cmd;

endpackage

[hw/rtl/group_release_fifo.sv]
// An accepted item is first captured, then committed into the result register once that
// register is free; the block takes no new item until the result is loaded. The head slot
// and the group id table sit in RAMs with registered read.
// A held output stalls the block until the result register frees up.
// Reset (i_rst_n low, synchronous) empties the queue; every entry of the id table is then
// cleared, and the input opens in the cycle after the clear finishes.
// ----------------------------------------------------------------------------
// group_release_fifo
// Strict-order FIFO of member groups; the head group leaves only when all of
// its members have been marked ready.
// ----------------------------------------------------------------------------
module group_release_fifo #(
    parameter int QUEUE_DEPTH   = grf_pkg::DEF_QUEUE_DEPTH,
    parameter int MEMBER_COUNT  = grf_pkg::DEF_MEMBER_COUNT,
    parameter int GROUP_ID_BITS = grf_pkg::DEF_GROUP_ID_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [grf_pkg::OP_W-1:0]     i_operation,
    input  logic [grf_pkg::GID_W-1:0]    i_group_id,
    input  logic [grf_pkg::MASK_W-1:0]   i_member_mask,
    input  logic [grf_pkg::IDX_W-1:0]    i_member_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [grf_pkg::STATUS_W-1:0] o_status,
    output logic [grf_pkg::GID_W-1:0]    o_released_group_id,
    output logic [grf_pkg::MASK_W-1:0]   o_released_members
);

    grf_pkg::t_cmd cmd;
    logic          clear_busy;

    grf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear_busy (clear_busy),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cmd        (cmd)
    );

    grf_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .MEMBER_COUNT  (MEMBER_COUNT),
        .GROUP_ID_BITS (GROUP_ID_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_clear_busy        (clear_busy),
        .i_operation         (i_operation),
        .i_group_id          (i_group_id),
        .i_member_mask       (i_member_mask),
        .i_member_index      (i_member_index),
        .o_status            (o_status),
        .o_released_group_id (o_released_group_id),
        .o_released_members  (o_released_members)
    );

endmodule

[hw/rtl/grf_ram.sv]
// ----------------------------------------------------------------------------
// grf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module grf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/grf_ctrl.sv]
// ----------------------------------------------------------------------------
// grf_ctrl
// Sequencer: holds the input off while the id table is cleared, then takes
// one item, waits for the head read and a free output register, then commits
// the item and presents its result.
// ----------------------------------------------------------------------------
module grf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear_busy,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output grf_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (!i_clear_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/grf_datapath.sv]
// ----------------------------------------------------------------------------
// grf_datapath
// Queue storage, member and id bookkeeping, and the result register.
// ----------------------------------------------------------------------------
module grf_datapath #(
    parameter int QUEUE_DEPTH   = grf_pkg::DEF_QUEUE_DEPTH,
    parameter int MEMBER_COUNT  = grf_pkg::DEF_MEMBER_COUNT,
    parameter int GROUP_ID_BITS = grf_pkg::DEF_GROUP_ID_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  grf_pkg::t_cmd                 i_cmd,
    output logic                          o_clear_busy,
    input  logic [grf_pkg::OP_W-1:0]      i_operation,
    input  logic [grf_pkg::GID_W-1:0]     i_group_id,
    input  logic [grf_pkg::MASK_W-1:0]    i_member_mask,
    input  logic [grf_pkg::IDX_W-1:0]     i_member_index,
    output logic [grf_pkg::STATUS_W-1:0]  o_status,
    output logic [grf_pkg::GID_W-1:0]     o_released_group_id,
    output logic [grf_pkg::MASK_W-1:0]    o_released_members
);

    localparam int PtrW    = $clog2(QUEUE_DEPTH);
    localparam int OccW    = $clog2(QUEUE_DEPTH + 1);
    localparam int MemBits = (MEMBER_COUNT < grf_pkg::MASK_W) ? MEMBER_COUNT
                                                               : grf_pkg::MASK_W;
    localparam int IdBits  = (GROUP_ID_BITS < grf_pkg::GID_W) ? GROUP_ID_BITS
                                                               : grf_pkg::GID_W;
    localparam int IdSpace = 1 << IdBits;
    localparam int SlotW   = IdBits + MemBits;

    // captured item
    logic [grf_pkg::OP_W-1:0]  r_op;
    logic [IdBits-1:0]         r_gid;
    logic [MemBits-1:0]        r_mask;
    logic [grf_pkg::IDX_W-1:0] r_idx;

    // queue bookkeeping
    logic [PtrW-1:0]    r_head, n_head;
    logic [PtrW-1:0]    r_tail, n_tail;
    logic [OccW-1:0]    r_occ, n_occ;
    logic [MemBits-1:0] r_busy, n_busy;
    // ready bits are global: a busy member belongs to exactly one queued slot
    logic [MemBits-1:0] r_ready, n_ready;

    // id-in-use table lives in RAM; a pass after reset clears every entry
    logic              r_clearing;
    logic [IdBits-1:0] r_clr_addr;
    logic              id_we;
    logic [IdBits-1:0] id_waddr;
    logic              id_wdata;
    logic [IdBits-1:0] id_raddr;
    logic              id_used;

    // result register
    logic [grf_pkg::STATUS_W-1:0] r_status, n_status;
    logic [grf_pkg::GID_W-1:0]    r_rel_gid, n_rel_gid;
    logic [grf_pkg::MASK_W-1:0]   r_rel_mask, n_rel_mask;

    logic [SlotW-1:0]          head_data;
    logic [IdBits-1:0]         head_gid;
    logic [MemBits-1:0]        head_mask;
    logic                      slot_we;
    logic [grf_pkg::MASK_W-1:0] idx_hot;
    logic [MemBits-1:0]        idx_sel;

    grf_ram #(
        .WIDTH (SlotW),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_tail),
        .i_wdata ({r_gid, r_mask}),
        .i_raddr (r_head),
        .o_rdata (head_data)
    );

    grf_ram #(
        .WIDTH (1),
        .DEPTH (IdSpace)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (id_wdata),
        .i_raddr (id_raddr),
        .o_rdata (id_used)
    );

    // look up the incoming id at capture, keep reading it while the item waits
    assign id_raddr  = i_cmd.capture ? i_group_id[IdBits-1:0] : r_gid;

    assign head_gid  = head_data[SlotW-1:MemBits];
    assign head_mask = head_data[MemBits-1:0];
    assign idx_hot   = grf_pkg::MASK_W'(1) << r_idx;
    assign idx_sel   = idx_hot[MemBits-1:0];   // zero when index is out of range

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_busy     = r_busy;
        n_ready    = r_ready;
        n_status   = grf_pkg::ST_WAITING;
        n_rel_gid  = '0;
        n_rel_mask = '0;
        slot_we    = 1'b0;
        id_we      = 1'b0;
        id_waddr   = r_gid;
        id_wdata   = 1'b0;
        case (r_op)
            grf_pkg::OP_ADMIT: begin
                if (r_mask == '0) begin
                    n_status = grf_pkg::ST_EMPTY;
                end else if (id_used) begin
                    n_status = grf_pkg::ST_DUP_ID;
                end else if ((r_mask & r_busy) != '0) begin
                    n_status = grf_pkg::ST_DUP_MEMBER;
                end else if (r_occ == OccW'(QUEUE_DEPTH)) begin
                    n_status = grf_pkg::ST_FULL;
                end else begin
                    n_status         = grf_pkg::ST_ADMITTED;
                    slot_we          = i_cmd.commit;
                    id_we            = i_cmd.commit;
                    id_wdata         = 1'b1;
                    n_busy           = r_busy | r_mask;
                    n_tail           = (r_tail == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_tail + 1'b1;
                    n_occ            = r_occ + 1'b1;
                end
            end
            grf_pkg::OP_READY: begin
                if ((r_busy & idx_sel) == '0) begin
                    n_status = grf_pkg::ST_UNKNOWN;
                end else begin
                    n_status = grf_pkg::ST_MARKED;
                    n_ready  = r_ready | idx_sel;
                end
            end
            grf_pkg::OP_RELEASE: begin
                if (r_occ != '0 && (r_ready & head_mask) == head_mask) begin
                    n_status            = grf_pkg::ST_RELEASED;
                    n_rel_gid           = grf_pkg::GID_W'(head_gid);
                    n_rel_mask          = grf_pkg::MASK_W'(head_mask);
                    id_we               = i_cmd.commit;
                    id_waddr            = head_gid;
                    n_busy              = r_busy & ~head_mask;
                    n_ready             = r_ready & ~head_mask;
                    n_head              = (r_head == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                             : r_head + 1'b1;
                    n_occ               = r_occ - 1'b1;
                end
            end
            default: begin
                n_status = grf_pkg::ST_WAITING;
            end
        endcase
        if (r_clearing) begin
            id_we    = 1'b1;
            id_waddr = r_clr_addr;
            id_wdata = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_gid  <= i_group_id[IdBits-1:0];
            r_mask <= i_member_mask[MemBits-1:0];
            r_idx  <= i_member_index;
        end
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_rel_gid  <= n_rel_gid;
            r_rel_mask <= n_rel_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_occ      <= '0;
            r_busy     <= '0;
            r_ready    <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IdBits'(IdSpace - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_occ   <= n_occ;
                r_busy  <= n_busy;
                r_ready <= n_ready;
            end
        end
    end

    assign o_clear_busy        = r_clearing;
    assign o_status            = r_status;
    assign o_released_group_id = r_rel_gid;
    assign o_released_members  = r_rel_mask;

endmodule

[hw/rtl/grf_checker.sv]
// ----------------------------------------------------------------------------
// grf_checker
// Port-level checks for the group release FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module grf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [grf_pkg::STATUS_W-1:0] o_status,
    input logic [grf_pkg::GID_W-1:0]    o_released_group_id,
    input logic [grf_pkg::MASK_W-1:0]   o_released_members
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_released_group_id)
            && $stable(o_released_members))
        else $error("result changed while stalled");

    // one item at a time: an accepted item stalls the input in the cycle after it is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // release fields are zero for every other status
    a_rel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != grf_pkg::ST_RELEASED |->
            o_released_group_id == '0 && o_released_members == '0)
        else $error("release fields set without a release");

    // a released group always has members
    a_rel_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == grf_pkg::ST_RELEASED |->
            o_released_members != '0)
        else $error("released group with no members");

    // reset leaves no result pending and holds the input for the id table clear
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("block not idle after reset");

endmodule

bind group_release_fifo grf_checker u_grf_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_status            (o_status),
    .o_released_group_id (o_released_group_id),
    .o_released_members  (o_released_members)
);
